>>> rtl/smbw_pkg.sv
// Shared types and constants for the SMBIOS structure table walker.
package smbw_pkg;

  // Walk phase within one structure
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_FORMAT,
    PH_STRINGS,
    PH_DONE
  } phase_t;

  // Result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SHORT   = 3'd1;
  localparam logic [2:0] ST_EXCEEDS = 3'd2;
  localparam logic [2:0] ST_END     = 3'd3;
  localparam logic [2:0] ST_TRUNC   = 3'd4;

  // Structure type that closes the table, and the wildcard handle
  localparam logic [7:0]  END_TYPE   = 8'd127;
  localparam logic [15:0] ANY_HANDLE = 16'hFFFF;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_MATCH_MODE    = 3'd0;
  localparam logic [2:0] REG_TARGET_TYPE   = 3'd1;
  localparam logic [2:0] REG_TARGET_HANDLE = 3'd2;
  localparam logic [2:0] REG_STRING_INDEX  = 3'd3;
  localparam logic [2:0] REG_TABLE_LENGTH  = 3'd4;

  localparam int unsigned CFG_ADDR_BITS = 5;

  // Search configuration as seen by the parser
  typedef struct packed {
    logic        match_mode;
    logic [7:0]  target_type;
    logic [15:0] target_handle;
    logic [7:0]  string_index;
    logic [15:0] table_length;
  } cfg_t;

  // One result beat; struct_type sits in the lowest bits
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] string_offset;
    logic        string_found;
    logic        matched;
    logic [15:0] struct_offset;
    logic [15:0] struct_handle;
    logic [7:0]  struct_length;
    logic [7:0]  struct_type;
  } res_t;

  localparam int unsigned RES_BITS   = $bits(res_t);
  localparam int unsigned TDATA_BITS = ((RES_BITS + 7) / 8) * 8;

endpackage

>>> rtl/smbw_cfg.sv
// APB register file holding the search configuration.
module smbw_cfg
  import smbw_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output cfg_t                     cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_ADDR_BITS-1:2];
  assign cfg     = cfg_r;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.match_mode    <= 1'b0;
      cfg_r.target_type   <= 8'd0;
      cfg_r.target_handle <= ANY_HANDLE;
      cfg_r.string_index  <= 8'd0;
      cfg_r.table_length  <= 16'd0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MATCH_MODE:    cfg_r.match_mode    <= pwdata[0];
        REG_TARGET_TYPE:   cfg_r.target_type   <= pwdata[7:0];
        REG_TARGET_HANDLE: cfg_r.target_handle <= pwdata[15:0];
        REG_STRING_INDEX:  cfg_r.string_index  <= pwdata[7:0];
        REG_TABLE_LENGTH:  cfg_r.table_length  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_MATCH_MODE:    prdata = {31'd0, cfg_r.match_mode};
      REG_TARGET_TYPE:   prdata = {24'd0, cfg_r.target_type};
      REG_TARGET_HANDLE: prdata = {16'd0, cfg_r.target_handle};
      REG_STRING_INDEX:  prdata = {24'd0, cfg_r.string_index};
      REG_TABLE_LENGTH:  prdata = {16'd0, cfg_r.table_length};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

>>> rtl/smbw_parse.sv
// Per-byte walk state and result formation for one table byte.
module smbw_parse
  import smbw_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] table_byte,
  input  logic       last_byte,
  input  cfg_t       cfg,
  output logic       res_valid,
  output res_t       res
);

  phase_t                 phase_r, phase_nxt;
  logic [OFFSET_BITS-1:0] byte_offset_r, byte_offset_nxt;
  logic [OFFSET_BITS-1:0] struct_start_r, struct_start_nxt;
  logic [OFFSET_BITS-1:0] found_offset_r, found_offset_nxt;
  logic [1:0]             header_count_r, header_count_nxt;
  logic [7:0]             cur_type_r, cur_type_nxt;
  logic [7:0]             cur_length_r, cur_length_nxt;
  logic [15:0]            cur_handle_r, cur_handle_nxt;
  logic [7:0]             string_number_r, string_number_nxt;
  logic                   previous_zero_r, previous_zero_nxt;
  logic                   found_flag_r, found_flag_nxt;

  logic                   walk_rst;
  logic                   emit;
  logic                   emit_match;
  logic                   emit_strings;
  logic                   emit_found;
  logic [OFFSET_BITS-1:0] emit_found_off;
  logic [2:0]             emit_status;
  logic [OFFSET_BITS-1:0] pos;
  logic                   first;
  logic                   is_match;
  logic [7:0]             sn_inc;
  logic [31:0]            start_w;
  logic [31:0]            found_w;

  assign pos    = byte_offset_r - struct_start_r;
  assign first  = (33'(pos) == 33'(cur_length_r));
  assign sn_inc = string_number_r + 8'd1;

  // Search match on the header of the structure in hand
  always_comb begin
    if (cfg.match_mode) begin
      is_match = (cur_handle_nxt == cfg.target_handle);
    end else begin
      is_match = (cur_type_nxt == cfg.target_type) &&
                 ((cfg.target_handle == ANY_HANDLE) || (cur_handle_nxt > cfg.target_handle));
    end
  end

  // Next walk state
  always_comb begin
    phase_nxt         = phase_r;
    byte_offset_nxt   = byte_offset_r;
    struct_start_nxt  = struct_start_r;
    found_offset_nxt  = found_offset_r;
    header_count_nxt  = header_count_r;
    cur_type_nxt      = cur_type_r;
    cur_length_nxt    = cur_length_r;
    cur_handle_nxt    = cur_handle_r;
    string_number_nxt = string_number_r;
    previous_zero_nxt = previous_zero_r;
    found_flag_nxt    = found_flag_r;
    walk_rst          = 1'b0;
    emit              = 1'b0;
    emit_match        = 1'b0;
    emit_strings      = 1'b0;
    emit_found        = 1'b0;
    emit_found_off    = '0;
    emit_status       = ST_OK;
    if (accept) begin
      walk_rst = last_byte;
      if (phase_r != PH_DONE) begin
        byte_offset_nxt = byte_offset_r + OFFSET_BITS'(1);
        case (phase_r)
          PH_HEADER: begin
            case (header_count_r)
              2'd0: begin
                struct_start_nxt = byte_offset_r;
                cur_type_nxt     = table_byte;
                cur_length_nxt   = 8'd0;
                cur_handle_nxt   = 16'd0;
                header_count_nxt = 2'd1;
              end
              2'd1: begin
                cur_length_nxt   = table_byte;
                header_count_nxt = 2'd2;
              end
              2'd2: begin
                cur_handle_nxt   = {8'd0, table_byte};
                header_count_nxt = 2'd3;
              end
              default: begin
                cur_handle_nxt   = {table_byte, cur_handle_r[7:0]};
                header_count_nxt = 2'd0;
                if (cur_length_r < 8'd4) begin
                  emit        = 1'b1;
                  emit_status = ST_SHORT;
                  phase_nxt   = PH_DONE;
                end else if (33'(struct_start_r) + 33'(cur_length_r) >
                             33'(cfg.table_length)) begin
                  emit        = 1'b1;
                  emit_status = ST_EXCEEDS;
                  phase_nxt   = PH_DONE;
                end else begin
                  phase_nxt         = (cur_length_r == 8'd4) ? PH_STRINGS : PH_FORMAT;
                  string_number_nxt = 8'd0;
                  previous_zero_nxt = 1'b0;
                  found_flag_nxt    = 1'b0;
                  found_offset_nxt  = '0;
                end
              end
            endcase
          end
          PH_FORMAT: begin
            if (33'(pos) + 33'd1 >= 33'(cur_length_r)) begin
              phase_nxt = PH_STRINGS;
            end
          end
          default: begin
            if (table_byte == 8'd0) begin
              if (first) begin
                // empty string area: no strings can match
                string_number_nxt = 8'd255;
                previous_zero_nxt = 1'b1;
              end else if (previous_zero_r) begin
                // double zero closes the structure; report strings found so far
                emit           = 1'b1;
                emit_match     = is_match;
                emit_strings   = 1'b1;
                emit_found     = found_flag_r;
                emit_found_off = found_offset_r;
                emit_status    = (cur_type_r == END_TYPE) ? ST_END : ST_OK;
                if (is_match || (cur_type_r == END_TYPE)) begin
                  phase_nxt = PH_DONE;
                end else begin
                  phase_nxt         = PH_HEADER;
                  header_count_nxt  = 2'd0;
                  string_number_nxt = 8'd0;
                  previous_zero_nxt = 1'b0;
                  found_offset_nxt  = '0;
                  found_flag_nxt    = 1'b0;
                end
              end else begin
                previous_zero_nxt = 1'b1;
              end
            end else begin
              // count a new string on its first byte
              if ((first || previous_zero_r) && (string_number_r != 8'd255)) begin
                string_number_nxt = sn_inc;
                if ((cfg.string_index != 8'd0) && (sn_inc == cfg.string_index)) begin
                  found_flag_nxt   = 1'b1;
                  found_offset_nxt = byte_offset_r;
                end
              end
              previous_zero_nxt = 1'b0;
            end
          end
        endcase
        // stream ends inside a structure
        if (last_byte && !emit) begin
          emit           = 1'b1;
          emit_strings   = 1'b1;
          emit_found     = found_flag_nxt;
          emit_found_off = found_offset_nxt;
          emit_status    = ST_TRUNC;
        end
      end
    end
  end

  assign start_w = 32'(struct_start_nxt);
  assign found_w = 32'(emit_found_off);

  // Result fields from the updated walk state
  always_comb begin
    res_valid         = emit;
    res.struct_type   = cur_type_nxt;
    res.struct_length = cur_length_nxt;
    res.struct_handle = cur_handle_nxt;
    res.struct_offset = start_w[15:0];
    res.matched       = emit_match;
    res.string_found  = emit_strings && emit_found;
    res.string_offset = (emit_strings && emit_found) ? found_w[15:0] : 16'd0;
    res.status        = emit_status;
  end

  // Hold walk state; last byte returns it to the start
  always_ff @(posedge clk) begin
    if (!rst_n || walk_rst) begin
      phase_r         <= PH_HEADER;
      byte_offset_r   <= '0;
      struct_start_r  <= '0;
      found_offset_r  <= '0;
      header_count_r  <= 2'd0;
      cur_type_r      <= 8'd0;
      cur_length_r    <= 8'd0;
      cur_handle_r    <= 16'd0;
      string_number_r <= 8'd0;
      previous_zero_r <= 1'b0;
      found_flag_r    <= 1'b0;
    end else begin
      phase_r         <= phase_nxt;
      byte_offset_r   <= byte_offset_nxt;
      struct_start_r  <= struct_start_nxt;
      found_offset_r  <= found_offset_nxt;
      header_count_r  <= header_count_nxt;
      cur_type_r      <= cur_type_nxt;
      cur_length_r    <= cur_length_nxt;
      cur_handle_r    <= cur_handle_nxt;
      string_number_r <= string_number_nxt;
      previous_zero_r <= previous_zero_nxt;
      found_flag_r    <= found_flag_nxt;
    end
  end

endmodule

>>> rtl/smbw_outq.sv
// Two-entry result buffer between the parser and the output channel.
module smbw_outq
  import smbw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic has_room,
  output logic pop_valid,
  input  logic pop_ready,
  output res_t pop_data
);

  res_t       slot0_r, slot0_nxt;
  res_t       slot1_r, slot1_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (count_r != 2'd0);
  assign pop_data  = slot0_r;
  assign has_room  = (count_r != 2'd2);

  // Advance the queue: slot0 is the head
  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    count_nxt = count_r;
    case ({push, pop})
      2'b10: begin
        if (count_r == 2'd0) begin
          slot0_nxt = push_data;
        end else begin
          slot1_nxt = push_data;
        end
        count_nxt = count_r + 2'd1;
      end
      2'b01: begin
        slot0_nxt = slot1_r;
        count_nxt = count_r - 2'd1;
      end
      2'b11: begin
        if (count_r == 2'd1) begin
          slot0_nxt = push_data;
        end else begin
          slot0_nxt = slot1_r;
          slot1_nxt = push_data;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

>>> rtl/smbios_structure_table_walker.sv
// SMBIOS structure table walker: top level with stream and register ports.
//
// Feed the structure table one byte per input beat (in_tdata), with in_tlast
// on the final byte of the table. For each structure that ends, and for each
// header error or truncated table, one result beat leaves on out_*: header
// fields, start offset, search match, requested string location and status.
// A match, an error or an end-of-table structure stops the search; bytes are
// then swallowed until in_tlast, which returns the walk to the table start.
// Program the search over the APB port while the block is idle.
//
// Throughput: one byte per cycle while in_tready is high. A byte is consumed
// in the cycle it is accepted; its result is registered in the result buffer.
// A two-entry result buffer sits in front of the output: a stalled receiver
// is absorbed by it, and in_tready drops only while both entries are full.
// Reset (synchronous, rst_n low) clears the walk and the buffer and loads
// the register defaults (target_handle 0xFFFF, all else zero).
module smbios_structure_table_walker
  import smbw_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // stream input: [7:0] table_byte; in_tlast carries last_byte
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,
  input  logic                     in_tlast,
  // results: [7:0] struct_type, [15:8] struct_length, [31:16] struct_handle,
  // [47:32] struct_offset, [48] matched, [49] string_found,
  // [65:50] string_offset, [68:66] status, [71:69] zero
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [TDATA_BITS-1:0]    out_tdata,
  // register port
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0]              cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);

  cfg_t cfg;
  res_t res;
  res_t head;
  logic res_valid;
  logic in_beat;

  assign cfg_pready = 1'b1;
  assign in_beat    = in_tvalid && in_tready;

  smbw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  smbw_parse #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_beat),
    .table_byte (in_tdata),
    .last_byte  (in_tlast),
    .cfg        (cfg),
    .res_valid  (res_valid),
    .res        (res)
  );

  smbw_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .has_room  (in_tready),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (head)
  );

  // Pad the result to whole bytes
  assign out_tdata = TDATA_BITS'(head);

endmodule

>>> tb/testbench.sv
// Self-checking stream testbench for the SMBIOS structure table walker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import smbw_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;

  // Tracks the walk over the table bytes and holds the reports still owed
  class structure_tracker;
    logic        sel_mode;
    logic [7:0]  sel_type;
    logic [15:0] sel_handle;
    logic [7:0]  sel_string;
    logic [15:0] tbl_length;

    logic [15:0] at;
    logic [15:0] start;
    phase_t      walk_phase;
    logic [1:0]  hdr_cnt;
    logic [7:0]  typ;
    logic [7:0]  len;
    logic [15:0] hnd;
    logic [7:0]  str_num;
    logic        prev_zero;
    logic [15:0] hit_off;
    logic        hit;
    logic        stopped;

    res_t reports[$];
    int   errors;

    function new();
      sel_mode   = 1'b0;
      sel_type   = '0;
      sel_handle = ANY_HANDLE;
      sel_string = '0;
      tbl_length = '0;
      errors     = 0;
      restart();
    endfunction

    function void restart();
      at         = '0;
      start      = '0;
      walk_phase = PH_HEADER;
      hdr_cnt    = '0;
      typ        = '0;
      len        = '0;
      hnd        = '0;
      str_num    = '0;
      prev_zero  = 1'b0;
      hit_off    = '0;
      hit        = 1'b0;
      stopped    = 1'b0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_MATCH_MODE:    sel_mode   = v[0];
        REG_TARGET_TYPE:   sel_type   = v[7:0];
        REG_TARGET_HANDLE: sel_handle = v[15:0];
        REG_STRING_INDEX:  sel_string = v[7:0];
        REG_TABLE_LENGTH:  tbl_length = v[15:0];
        default: ;
      endcase
    endfunction

    function logic hits_search();
      if (sel_mode)
        return hnd == sel_handle;
      return (typ == sel_type) && (sel_handle == ANY_HANDLE || hnd > sel_handle);
    endfunction

    function void report(logic m, logic with_strings, logic [2:0] st);
      res_t r;
      r.struct_type   = typ;
      r.struct_length = len;
      r.struct_handle = hnd;
      r.struct_offset = start;
      r.matched       = m;
      r.string_found  = with_strings & hit;
      r.string_offset = (with_strings && hit) ? hit_off : 16'h0000;
      r.status        = st;
      reports.push_back(r);
    endfunction

    // Advance the walk by one accepted table byte
    function void take_byte(logic [7:0] b, logic last);
      logic [15:0] off;
      logic [15:0] pos;
      logic        first;
      logic        m;
      if (stopped || walk_phase == PH_DONE) begin
        if (last)
          restart();
        return;
      end
      off = at;
      at  = at + 16'd1;
      pos = off - start;
      case (walk_phase)
        PH_HEADER: begin
          case (hdr_cnt)
            2'd0: begin
              start   = off;
              typ     = b;
              len     = '0;
              hnd     = '0;
              hdr_cnt = 2'd1;
            end
            2'd1: begin
              len     = b;
              hdr_cnt = 2'd2;
            end
            2'd2: begin
              hnd     = {8'h00, b};
              hdr_cnt = 2'd3;
            end
            default: begin
              hnd[15:8] = b;
              hdr_cnt   = 2'd0;
              // header errors stop the search at once
              if (len < 8'd4 || int'(start) + int'(len) > int'(tbl_length)) begin
                report(1'b0, 1'b0, (len < 8'd4) ? ST_SHORT : ST_EXCEEDS);
                stopped    = 1'b1;
                walk_phase = PH_DONE;
                if (last)
                  restart();
                return;
              end
              walk_phase = (len == 8'd4) ? PH_STRINGS : PH_FORMAT;
              str_num    = '0;
              prev_zero  = 1'b0;
              hit        = 1'b0;
              hit_off    = '0;
            end
          endcase
        end
        PH_FORMAT: begin
          if (int'(pos) + 1 >= int'(len))
            walk_phase = PH_STRINGS;
        end
        default: begin
          first = (pos == 16'(len));
          if (b == 8'h00) begin
            if (first) begin
              // empty string area
              str_num   = 8'hFF;
              prev_zero = 1'b1;
            end else if (prev_zero) begin
              m = hits_search();
              report(m, 1'b1, (typ == END_TYPE) ? ST_END : ST_OK);
              if (m || typ == END_TYPE) begin
                stopped    = 1'b1;
                walk_phase = PH_DONE;
              end else begin
                walk_phase = PH_HEADER;
                hdr_cnt    = '0;
                str_num    = '0;
                prev_zero  = 1'b0;
                hit        = 1'b0;
                hit_off    = '0;
              end
              if (last)
                restart();
              return;
            end else begin
              prev_zero = 1'b1;
            end
          end else begin
            // count string starts, saturating at 255
            if ((first || prev_zero) && str_num != 8'hFF) begin
              str_num++;
              if (sel_string != 8'h00 && str_num == sel_string) begin
                hit     = 1'b1;
                hit_off = off;
              end
            end
            prev_zero = 1'b0;
          end
        end
      endcase
      if (last) begin
        report(1'b0, 1'b1, ST_TRUNC);
        restart();
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one result beat with the oldest owed report
    function void check_report(logic [TDATA_BITS-1:0] d);
      res_t want;
      res_t got;
      got = res_t'(d[RES_BITS-1:0]);
      if (reports.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual 0x%0h", $time, d);
        errors++;
        return;
      end
      want = reports.pop_front();
      compare_field("struct_type", 16'(want.struct_type), 16'(got.struct_type));
      compare_field("struct_length", 16'(want.struct_length), 16'(got.struct_length));
      compare_field("struct_handle", want.struct_handle, got.struct_handle);
      compare_field("struct_offset", want.struct_offset, got.struct_offset);
      compare_field("matched", 16'(want.matched), 16'(got.matched));
      compare_field("string_found", 16'(want.string_found), 16'(got.string_found));
      compare_field("string_offset", want.string_offset, got.string_offset);
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("padding", 16'h0000, 16'(d[TDATA_BITS-1:RES_BITS]));
    endfunction
  endclass

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     in_tvalid   = 1'b0;
  logic                     in_tready;
  logic [7:0]               in_tdata    = '0;
  logic                     in_tlast    = 1'b0;
  logic                     out_tvalid;
  logic                     out_tready  = 1'b0;
  logic [TDATA_BITS-1:0]    out_tdata;
  logic                     cfg_psel    = 1'b0;
  logic                     cfg_penable = 1'b0;
  logic                     cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr   = '0;
  logic [31:0]              cfg_pwdata  = '0;
  logic [31:0]              cfg_prdata;
  logic                     cfg_pready;

  int send_idle    = 0;
  int recv_stall   = 0;
  int quiet_cycles = 0;

  // search settings as last programmed, used to steer the table contents
  logic [7:0]  want_type   = '0;
  logic [15:0] want_handle = ANY_HANDLE;

  structure_tracker tracker = new();

  smbios_structure_table_walker DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  // Watch beats and register writes
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        tracker.check_report(out_tdata);
      if (in_tvalid && in_tready)
        tracker.take_byte(in_tdata, in_tlast);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)
        tracker.write_reg(cfg_paddr[CFG_ADDR_BITS-1:2], cfg_pwdata);
    end
  end

  // Drop the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
  endtask

  // Hold the input until every owed report is out and the block is quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic mode, logic [7:0] typ, logic [15:0] hnd, logic [7:0] sidx,
                           logic [15:0] tlen);
    settle();
    want_type   = typ;
    want_handle = hnd;
    set_reg(REG_MATCH_MODE, 32'(mode));
    set_reg(REG_TARGET_TYPE, 32'(typ));
    set_reg(REG_TARGET_HANDLE, 32'(hnd));
    set_reg(REG_STRING_INDEX, 32'(sidx));
    set_reg(REG_TABLE_LENGTH, 32'(tlen));
  endtask

  task automatic send_table(logic [7:0] bytes[$]);
    foreach (bytes[i])
      push_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // Append one well-formed structure with nstr strings of 1..max_chars bytes
  task automatic add_struct(ref logic [7:0] q[$], input logic [7:0] typ, input logic [7:0] len,
                            input logic [15:0] hnd, input int nstr, input int max_chars);
    q.push_back(typ);
    q.push_back(len);
    q.push_back(hnd[7:0]);
    q.push_back(hnd[15:8]);
    repeat (int'(len) - 4)
      q.push_back(8'($urandom_range(255)));
    repeat (nstr) begin
      repeat ($urandom_range(1, max_chars))
        q.push_back(8'($urandom_range(1, 255)));
      q.push_back(8'h00);
    end
    if (nstr == 0)
      q.push_back(8'h00);
    q.push_back(8'h00);
  endtask

  // Mostly valid structures aimed near the search, with some broken endings
  task automatic build_table(ref logic [7:0] q[$]);
    int          pick;
    logic [7:0]  typ;
    logic [7:0]  len;
    logic [15:0] hnd;
    q.delete();
    repeat ($urandom_range(1, 4)) begin
      pick = $urandom_range(19);
      typ  = (pick < 9) ? want_type : (pick == 19) ? END_TYPE : 8'($urandom_range(255));
      case ($urandom_range(5))
        0:       hnd = want_handle;
        1:       hnd = want_handle + 16'd1;
        2:       hnd = want_handle - 16'd1;
        3:       hnd = $urandom_range(1) ? ANY_HANDLE : 16'h0000;
        default: hnd = 16'($urandom_range(65535));
      endcase
      len = ($urandom_range(29) == 0) ? 8'($urandom_range(200, 255)) : 8'($urandom_range(4, 12));
      add_struct(q, typ, len, hnd, $urandom_range(4), 4);
    end
    case ($urandom_range(9))
      0: begin
        // malformed header followed by junk
        q.push_back(8'($urandom_range(255)));
        q.push_back(8'($urandom_range(3)));
        repeat ($urandom_range(2, 6))
          q.push_back(8'($urandom_range(255)));
      end
      1: begin
        // table cut short
        if (q.size() > 1)
          q = q[0:$urandom_range(q.size() - 2)];
      end
      default: ;
    endcase
  endtask

  initial begin
    logic [7:0]  tbl[$];
    logic [15:0] tlen;
    int          sent;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: match with string, short header, truncation, end type, past the table
    configure(1'b0, 8'd1, ANY_HANDLE, 8'd1, 16'hFFFF);
    send_table('{8'h01, 8'h05, 8'h34, 8'h12, 8'hFF, 8'h41, 8'h00, 8'h00});
    send_table('{8'hFF, 8'h03, 8'hFF, 8'hFF, 8'hAA});
    send_table('{8'h7F, 8'h04, 8'h01, 8'h00, 8'h41});
    send_table('{8'h7F, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00});
    settle();
    set_reg(REG_TABLE_LENGTH, 32'd6);
    send_table('{8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h05, 8'h00, 8'h00});

    // random tables under each idling pattern
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       configure(1'b0, 8'h00, 16'h0000, 8'h00, 16'h0000);
        1:       configure(1'b1, 8'hFF, ANY_HANDLE, 8'hFF, 16'hFFFF);
        default: configure(1'($urandom_range(1)),
                           ($urandom_range(3) == 0) ? END_TYPE : 8'($urandom_range(255)),
                           $urandom_range(1) ? ANY_HANDLE : 16'($urandom_range(65535)),
                           ($urandom_range(7) == 0) ? 8'hFF : 8'($urandom_range(4)),
                           16'hFFFF);
      endcase
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 77; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 77; end
        default: begin send_idle = 13; recv_stall = 13; end
      endcase
      sent = 0;
      while (sent < 40) begin
        build_table(tbl);
        if ($urandom_range(3) == 0) begin
          case ($urandom_range(3))
            0:       tlen = 16'(tbl.size());
            1:       tlen = 16'($urandom_range(tbl.size()));
            2:       tlen = 16'hFFFF;
            default: tlen = 16'h0000;
          endcase
          settle();
          set_reg(REG_TABLE_LENGTH, 32'(tlen));
        end
        send_table(tbl);
        sent += tbl.size();
      end
    end

    settle();
    repeat (4) @(posedge clk);
    if (tracker.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
